// ===== hw/rtl/bjs_pkg.sv =====
// Package for the bounded job stack: field widths, action codes, beat and
// memory entry types, controller states. No dependencies.
`timescale 1ns / 1ps

package bjs_pkg;

  localparam int SLOTS_DEFAULT = 16;
  localparam int ACT_W = 3;
  localparam int ID_W = 31;
  localparam int PAY_W = 64;

  localparam logic [ACT_W-1:0] ACT_PUSH = 3'd0;
  localparam logic [ACT_W-1:0] ACT_PEEK = 3'd1;
  localparam logic [ACT_W-1:0] ACT_PULL = 3'd2;
  localparam logic [ACT_W-1:0] ACT_FIND = 3'd3;
  localparam logic [ACT_W-1:0] ACT_CUT  = 3'd4;

  typedef struct packed {
    logic [ACT_W-1:0] action;
    logic [ID_W-1:0]  entry_id;
    logic [PAY_W-1:0] entry_payload;
  } in_item_t;

  typedef struct packed {
    logic [ID_W-1:0]  out_id;
    logic [PAY_W-1:0] out_payload;
    logic             hit;
    logic             evicted_valid;
    logic [ID_W-1:0]  evicted_id;
  } out_item_t;

  typedef struct packed {
    logic [ID_W-1:0]  id;
    logic [PAY_W-1:0] payload;
  } mem_entry_t;

  localparam int ENTRY_W = $bits(mem_entry_t);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVICT,
    ST_READ,
    ST_FIND,
    ST_CUT
  } state_t;

endpackage

// ===== hw/rtl/bjs_if.sv =====
// Valid/ready channels for the job stack: request beats and result beats.
// Depends on bjs_pkg.
`timescale 1ns / 1ps

interface bjs_in_if import bjs_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface bjs_out_if import bjs_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== hw/rtl/bjs_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps

module bjs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/bounded_job_stack_with_eviction.sv =====
// Bounded job stack with oldest-entry eviction; ring of SLOTS entries in bjs_ram.
// Depends on bjs_pkg, bjs_if, bjs_ram.
// Push without eviction, failing ops and short cut answer from the idle state; push
// with eviction, peek and pull take the registered RAM read in ST_EVICT or ST_READ;
// find walks entries in ST_FIND and cut moves entries in ST_CUT. One request at a
// time; the single read port walks one entry per cycle.
// Reset (synchronous, rst high): stack empty, cursor cleared; storage left as is.
`timescale 1ns / 1ps

module bounded_job_stack_with_eviction import bjs_pkg::*; #(
  parameter int SLOTS = SLOTS_DEFAULT
) (
  input logic       clk,
  input logic       rst,
  bjs_in_if.sink    in_ch,
  bjs_out_if.source out_ch
);

  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam logic [IDX_W-1:0] LAST = IDX_W'(SLOTS - 1);

  function automatic logic [IDX_W-1:0] next_slot(input logic [IDX_W-1:0] i);
    return (i == LAST) ? '0 : i + 1'b1;
  endfunction

  function automatic logic [IDX_W-1:0] prev_slot(input logic [IDX_W-1:0] i);
    return (i == '0) ? LAST : i - 1'b1;
  endfunction

  state_t           state, state_next;
  logic [IDX_W-1:0] top_index, top_index_next;
  logic [IDX_W-1:0] bottom_index, bottom_index_next;
  logic [IDX_W-1:0] cursor_index, cursor_index_next;
  logic             cursor_valid, cursor_valid_next;
  logic [IDX_W-1:0] walk_index, walk_index_next;
  logic [ID_W-1:0]  find_id, find_id_next;
  logic             out_valid, out_valid_next;
  out_item_t        out_item, out_item_next;

  logic             mem_we;
  logic [IDX_W-1:0] mem_waddr;
  mem_entry_t       mem_wdata;
  logic [IDX_W-1:0] mem_raddr;
  mem_entry_t       mem_rdata;

  logic             accept;
  logic             empty;
  logic             full;
  logic [IDX_W-1:0] below_top;
  logic             find_match;
  logic             find_last;
  logic             cut_last;
  logic             cut_ok;
  logic             load_out;
  out_item_t        result;

  bjs_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (SLOTS)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign in_ch.ready = (state == ST_IDLE) && (!out_valid || out_ch.ready);
  assign accept      = in_ch.valid && in_ch.ready;
  assign out_ch.valid = out_valid;
  assign out_ch.data  = out_item;

  assign empty      = (top_index == bottom_index);
  assign full       = (next_slot(top_index) == bottom_index);
  assign below_top  = prev_slot(top_index);
  assign find_match = (mem_rdata.id == find_id);
  assign find_last  = (walk_index == bottom_index);
  assign cut_last   = (next_slot(walk_index) == top_index);
  assign cut_ok     = cursor_valid && !empty;

  always_comb begin
    state_next = state;
    if (state == ST_IDLE) begin
      if (accept) begin
        unique case (in_ch.data.action) inside
          ACT_PUSH: begin
            if (full) begin
              state_next = ST_EVICT;
            end
          end
          ACT_PEEK, ACT_PULL: begin
            if (!empty) begin
              state_next = ST_READ;
            end
          end
          ACT_FIND: begin
            if (in_ch.data.entry_id != '0 && !empty) begin
              state_next = ST_FIND;
            end
          end
          ACT_CUT: begin
            if (cut_ok && cursor_index != below_top) begin
              state_next = ST_CUT;
            end
          end
          default: state_next = ST_IDLE;
        endcase
      end
    end else if (state == ST_FIND) begin
      if (find_match || find_last) begin
        state_next = ST_IDLE;
      end
    end else if (state == ST_CUT) begin
      if (cut_last) begin
        state_next = ST_IDLE;
      end
    end else begin
      state_next = ST_IDLE;
    end
  end

  always_comb begin
    top_index_next    = top_index;
    bottom_index_next = bottom_index;
    cursor_index_next = cursor_index;
    cursor_valid_next = cursor_valid;
    walk_index_next   = walk_index;
    find_id_next      = find_id;
    mem_we            = 1'b0;
    mem_waddr         = top_index;
    mem_wdata         = '{id: in_ch.data.entry_id, payload: in_ch.data.entry_payload};
    mem_raddr         = below_top;
    load_out          = 1'b0;
    result            = '0;

    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          unique case (in_ch.data.action) inside
            ACT_PUSH: begin
              mem_we         = 1'b1;
              top_index_next = next_slot(top_index);
              if (full) begin
                bottom_index_next = next_slot(bottom_index);
                mem_raddr         = bottom_index;
                if (cursor_valid && cursor_index == bottom_index) begin
                  cursor_valid_next = 1'b0;
                end
              end else begin
                load_out   = 1'b1;
                result.hit = 1'b1;
              end
            end
            ACT_PEEK, ACT_PULL: begin
              if (empty) begin
                load_out = 1'b1;
              end else if (in_ch.data.action == ACT_PULL) begin
                top_index_next = below_top;
                if (cursor_valid && cursor_index == below_top) begin
                  cursor_valid_next = 1'b0;
                end
              end
            end
            ACT_FIND: begin
              cursor_valid_next = 1'b0;
              find_id_next      = in_ch.data.entry_id;
              walk_index_next   = below_top;
              if (in_ch.data.entry_id == '0 || empty) begin
                load_out = 1'b1;
              end
            end
            ACT_CUT: begin
              if (cut_ok) begin
                cursor_valid_next = 1'b0;
                top_index_next    = below_top;
                walk_index_next   = cursor_index;
                mem_raddr         = next_slot(cursor_index);
                if (cursor_index == below_top) begin
                  load_out   = 1'b1;
                  result.hit = 1'b1;
                end
              end else begin
                load_out = 1'b1;
              end
            end
            default: load_out = 1'b1;
          endcase
        end
      end
      ST_EVICT: begin
        load_out             = 1'b1;
        result.hit           = 1'b1;
        result.evicted_valid = 1'b1;
        result.evicted_id    = mem_rdata.id;
      end
      ST_READ: begin
        load_out           = 1'b1;
        result.hit         = 1'b1;
        result.out_id      = mem_rdata.id;
        result.out_payload = mem_rdata.payload;
      end
      ST_FIND: begin
        if (find_match) begin
          cursor_index_next  = walk_index;
          cursor_valid_next  = 1'b1;
          load_out           = 1'b1;
          result.hit         = 1'b1;
          result.out_id      = mem_rdata.id;
          result.out_payload = mem_rdata.payload;
        end else if (find_last) begin
          load_out = 1'b1;
        end else begin
          walk_index_next = prev_slot(walk_index);
          mem_raddr       = prev_slot(walk_index);
        end
      end
      ST_CUT: begin
        mem_we          = 1'b1;
        mem_waddr       = walk_index;
        mem_wdata       = mem_rdata;
        walk_index_next = next_slot(walk_index);
        mem_raddr       = next_slot(next_slot(walk_index));
        if (cut_last) begin
          load_out   = 1'b1;
          result.hit = 1'b1;
        end
      end
      default: load_out = 1'b0;
    endcase

    out_valid_next = out_valid && !out_ch.ready;
    out_item_next  = out_item;
    if (load_out) begin
      out_valid_next = 1'b1;
      out_item_next  = result;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      top_index    <= '0;
      bottom_index <= '0;
      cursor_index <= '0;
      cursor_valid <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      state        <= state_next;
      top_index    <= top_index_next;
      bottom_index <= bottom_index_next;
      cursor_index <= cursor_index_next;
      cursor_valid <= cursor_valid_next;
      out_valid    <= out_valid_next;
    end
    walk_index <= walk_index_next;
    find_id    <= find_id_next;
    out_item   <= out_item_next;
  end

`ifndef NO_ASSERTIONS
  a_index_range: assert property (@(posedge clk) disable iff (rst)
    (top_index <= LAST) && (bottom_index <= LAST))
    else $error("stack index beyond ring");

  a_push_advance: assert property (@(posedge clk) disable iff (rst)
    accept && in_ch.data.action == ACT_PUSH |=> top_index == next_slot($past(top_index)))
    else $error("push did not advance top");

  a_cut_bound: assert property (@(posedge clk) disable iff (rst)
    state == ST_CUT |-> walk_index != top_index)
    else $error("cut walk reached top");

  a_result_idle: assert property (@(posedge clk) disable iff (rst)
    $rose(out_ch.valid) |-> state == ST_IDLE)
    else $error("result beat loaded while busy");

  a_cut_clears: assert property (@(posedge clk) disable iff (rst)
    accept && in_ch.data.action == ACT_CUT |=> !cursor_valid)
    else $error("cursor survived cut");
`endif

endmodule

// ===== verif/tb_bounded_job_stack_with_eviction.sv =====
// Testbench for bounded_job_stack_with_eviction: a directed table, then random
// request beats under three idle patterns; each result is checked against the
// table's value or a local stack model. Depends on bjs_pkg, bjs_if and the block itself.
`timescale 1ns / 1ps

module tb_bounded_job_stack_with_eviction import bjs_pkg::*; ();

  localparam int SLOTS = SLOTS_DEFAULT;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 2 * SLOTS + 8;
  localparam int HOLD_CYCLES = 300;
  localparam int PHASE_BEATS = 630;
  localparam logic [ACT_W-1:0] ACT_SPARE_LO = 3'd5;
  localparam logic [ACT_W-1:0] ACT_SPARE_HI = 3'd7;
  localparam logic [ID_W-1:0] ID_MAX = {ID_W{1'b1}};

  typedef struct {
    logic [ACT_W-1:0] action;
    logic [ID_W-1:0]  id;
    logic [PAY_W-1:0] pay;
    int               reps;
    bit               fixed;
    out_item_t        res;
  } plan_row_t;

  logic clk;
  logic rst;

  bjs_in_if  req_ch ();
  bjs_out_if rsp_ch ();

  bounded_job_stack_with_eviction #(.SLOTS(SLOTS)) DUT (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (req_ch),
    .out_ch (rsp_ch)
  );

  logic [ID_W-1:0]  slot_id  [SLOTS];
  logic [PAY_W-1:0] slot_pay [SLOTS];
  int base_ix = 0;
  int head_ix = 0;
  int mark_ix = 0;
  bit mark_vld = 1'b0;

  out_item_t result_q [$];
  plan_row_t plan [$];
  int mism_cnt = 0;
  int cycle_cnt = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  bit hold_req = 1'b0;
  int hold_left = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic out_item_t stack_apply(in_item_t it);
    out_item_t r;
    bit empty;
    int below;
    int ix;
    int n;
    r = '0;
    empty = (head_ix == base_ix);
    below = (head_ix + SLOTS - 1) % SLOTS;
    case (it.action)
      ACT_PUSH: begin
        if ((head_ix + 1) % SLOTS == base_ix) begin
          r.evicted_valid = 1'b1;
          r.evicted_id = slot_id[base_ix];
          if (mark_vld && mark_ix == base_ix) mark_vld = 1'b0;
          base_ix = (base_ix + 1) % SLOTS;
        end
        slot_id[head_ix] = it.entry_id;
        slot_pay[head_ix] = it.entry_payload;
        head_ix = (head_ix + 1) % SLOTS;
        r.hit = 1'b1;
      end
      ACT_PEEK, ACT_PULL: begin
        if (!empty) begin
          r.out_id = slot_id[below];
          r.out_payload = slot_pay[below];
          r.hit = 1'b1;
          if (it.action == ACT_PULL) begin
            if (mark_vld && mark_ix == below) mark_vld = 1'b0;
            head_ix = below;
          end
        end
      end
      ACT_FIND: begin
        mark_vld = 1'b0;
        if (it.entry_id != '0 && !empty) begin
          ix = below;
          for (n = 0; n < SLOTS; n++) begin
            if (slot_id[ix] == it.entry_id) begin
              mark_ix = ix;
              mark_vld = 1'b1;
              r.out_id = slot_id[ix];
              r.out_payload = slot_pay[ix];
              r.hit = 1'b1;
              break;
            end
            if (ix == base_ix) break;
            ix = (ix + SLOTS - 1) % SLOTS;
          end
        end
      end
      ACT_CUT: begin
        if (mark_vld && !empty) begin
          ix = mark_ix;
          for (n = 0; n < SLOTS && (ix + 1) % SLOTS != head_ix; n++) begin
            slot_id[ix] = slot_id[(ix + 1) % SLOTS];
            slot_pay[ix] = slot_pay[(ix + 1) % SLOTS];
            ix = (ix + 1) % SLOTS;
          end
          head_ix = below;
          mark_vld = 1'b0;
          r.hit = 1'b1;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic out_item_t result_of(logic [ID_W-1:0] id, logic [PAY_W-1:0] pay,
                                          logic hit, logic ev, logic [ID_W-1:0] ev_id);
    out_item_t r;
    r.out_id = id;
    r.out_payload = pay;
    r.hit = hit;
    r.evicted_valid = ev;
    r.evicted_id = ev_id;
    return r;
  endfunction

  function automatic plan_row_t row(logic [ACT_W-1:0] action, logic [ID_W-1:0] id,
                                    logic [PAY_W-1:0] pay, int reps, bit fixed,
                                    out_item_t res);
    plan_row_t p;
    p.action = action;
    p.id = id;
    p.pay = pay;
    p.reps = reps;
    p.fixed = fixed;
    p.res = res;
    return p;
  endfunction

  function automatic in_item_t make_item(logic [ACT_W-1:0] action, logic [ID_W-1:0] id,
                                         logic [PAY_W-1:0] pay);
    in_item_t it;
    it.action = action;
    it.entry_id = id;
    it.entry_payload = pay;
    return it;
  endfunction

  // Entered and left at a falling edge.
  task automatic send_beat(in_item_t it, bit fixed, out_item_t res);
    out_item_t got;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(negedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.data <= it;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    got = stack_apply(it);
    result_q.push_back(fixed ? res : got);
    @(negedge clk);
  endtask

  function automatic logic [ID_W-1:0] pick_id();
    int r;
    r = $urandom_range(0, 99);
    if (r < 8) return '0;
    if (r < 75) return ID_W'($urandom_range(1, 20));
    return ID_W'($urandom);
  endfunction

  task automatic run_random(int beats);
    int done;
    int r;
    int push_w;
    int pull_w;
    out_item_t none;
    none = '0;
    done = 0;
    while (done < beats) begin
      // alternate between growing and shrinking the stack
      push_w = ((done / 150) % 2 == 0) ? 42 : 20;
      pull_w = ((done / 150) % 2 == 0) ? 13 : 35;
      r = $urandom_range(0, 99);
      if (r < push_w) begin
        send_beat(make_item(ACT_PUSH, pick_id(), {$urandom, $urandom}), 1'b0, none);
      end else if (r < push_w + pull_w) begin
        send_beat(make_item(ACT_PULL, ID_W'($urandom), {$urandom, $urandom}), 1'b0, none);
      end else if (r < push_w + pull_w + 8) begin
        send_beat(make_item(ACT_PEEK, ID_W'($urandom), {$urandom, $urandom}), 1'b0, none);
      end else if (r < push_w + pull_w + 20) begin
        send_beat(make_item(ACT_FIND, ID_W'($urandom_range(1, 20)), {$urandom, $urandom}),
                  1'b0, none);
      end else if (r < push_w + pull_w + 34) begin
        send_beat(make_item(ACT_FIND, ID_W'($urandom_range(1, 20)), {$urandom, $urandom}),
                  1'b0, none);
        send_beat(make_item(ACT_CUT, ID_W'($urandom), {$urandom, $urandom}), 1'b0, none);
        done++;
      end else if (r < push_w + pull_w + 37) begin
        send_beat(make_item(ACT_FIND, pick_id(), {$urandom, $urandom}), 1'b0, none);
      end else if (r < push_w + pull_w + 40) begin
        send_beat(make_item(ACT_CUT, ID_W'($urandom), {$urandom, $urandom}), 1'b0, none);
      end else begin
        send_beat(make_item(ACT_W'($urandom_range(ACT_SPARE_LO, ACT_SPARE_HI)),
                            ID_W'($urandom), {$urandom, $urandom}), 1'b0, none);
      end
      done++;
    end
  endtask

  initial begin
    out_item_t none;
    out_item_t push_ok;
    rst = 1'b1;
    req_ch.valid = 1'b0;
    req_ch.data = '0;
    rsp_ch.ready = 1'b0;
    for (int s = 0; s < SLOTS; s++) begin
      slot_id[s] = '0;
      slot_pay[s] = '0;
    end
    none = '0;
    push_ok = result_of('0, '0, 1'b1, 1'b0, '0);

    plan.push_back(row(ACT_PEEK, '0, '0, 1, 1'b1, none));
    plan.push_back(row(ACT_PULL, '0, '0, 1, 1'b1, none));
    plan.push_back(row(ACT_FIND, ID_MAX, '0, 1, 1'b1, none));
    plan.push_back(row(ACT_CUT, '0, '0, 1, 1'b1, none));
    plan.push_back(row(ACT_SPARE_LO, ID_MAX, '1, 1, 1'b1, none));
    plan.push_back(row(ACT_SPARE_HI, ID_MAX, '1, 1, 1'b1, none));
    plan.push_back(row(ACT_PUSH, ID_MAX, '1, 1, 1'b1, push_ok));
    plan.push_back(row(ACT_FIND, ID_MAX, '0, 1, 1'b0, none));
    plan.push_back(row(ACT_PULL, '0, '0, 1, 1'b0, none));
    plan.push_back(row(ACT_CUT, '0, '0, 1, 1'b1, none));
    plan.push_back(row(ACT_PUSH, 31'h2A, 64'h0123_4567_89AB_CDEF, 1, 1'b1, push_ok));
    plan.push_back(row(ACT_PUSH, '0, '0, 1, 1'b1, push_ok));
    plan.push_back(row(ACT_FIND, '0, '0, 1, 1'b1, none));
    plan.push_back(row(ACT_FIND, 31'h2A, '0, 1, 1'b0, none));
    plan.push_back(row(ACT_PUSH, 31'd1, 64'hA5A5_5A5A_0F0F_F0F0, 13, 1'b1, push_ok));
    plan.push_back(row(ACT_PUSH, 31'h55, '1, 1, 1'b1,
                       result_of('0, '0, 1'b1, 1'b1, 31'h2A)));
    plan.push_back(row(ACT_CUT, '0, '0, 1, 1'b1, none));
    plan.push_back(row(ACT_FIND, 31'h55, '0, 1, 1'b0, none));
    plan.push_back(row(ACT_CUT, '0, '0, 1, 1'b1, push_ok));
    plan.push_back(row(ACT_FIND, 31'd5, '0, 1, 1'b0, none));
    plan.push_back(row(ACT_CUT, '0, '0, 1, 1'b1, push_ok));
    plan.push_back(row(ACT_FIND, 31'h12345, '0, 1, 1'b1, none));
    plan.push_back(row(ACT_PEEK, '0, '0, 1, 1'b0, none));
    plan.push_back(row(ACT_PUSH, 31'h40, 64'hFFFF_0000_FFFF_0000, 3, 1'b0, none));
    plan.push_back(row(ACT_PULL, '0, '0, 1, 1'b0, none));

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    send_idle_pct = 25;
    recv_idle_pct = 46;
    foreach (plan[p]) begin
      for (int k = 0; k < plan[p].reps; k++) begin
        send_beat(make_item(plan[p].action, plan[p].id + ID_W'(k), plan[p].pay + PAY_W'(k)),
                  plan[p].fixed, plan[p].res);
      end
    end
    run_random(PHASE_BEATS);
    send_idle_pct = 46;
    recv_idle_pct = 25;
    run_random(PHASE_BEATS);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_req = 1'b1;
    run_random(PHASE_BEATS);

    req_ch.valid <= 1'b0;
    while (result_q.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mism_cnt == 0 && result_q.size() == 0) begin
      $display("PASS bounded_job_stack_with_eviction");
    end else begin
      $display("FAIL bounded_job_stack_with_eviction");
    end
    $finish;
  end

  // Receiver: random stalls, plus one long hold-off on request.
  initial begin
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    out_item_t want;
    out_item_t seen;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      seen = rsp_ch.data;
      if (result_q.size() == 0) begin
        mism_cnt++;
        if (mism_cnt <= 10)
          $display("unexpected result beat: id=%h pay=%h hit=%b ev=%b ev_id=%h",
                   seen.out_id, seen.out_payload, seen.hit, seen.evicted_valid,
                   seen.evicted_id);
      end else begin
        want = result_q.pop_front();
        if (seen.out_id !== want.out_id || seen.out_payload !== want.out_payload ||
            seen.hit !== want.hit || seen.evicted_valid !== want.evicted_valid ||
            seen.evicted_id !== want.evicted_id) begin
          mism_cnt++;
          if (mism_cnt <= 10)
            $display("result mismatch: expected id=%h pay=%h hit=%b ev=%b ev_id=%h,",
                     want.out_id, want.out_payload, want.hit, want.evicted_valid,
                     want.evicted_id,
                     " got id=%h pay=%h hit=%b ev=%b ev_id=%h",
                     seen.out_id, seen.out_payload, seen.hit,
                     seen.evicted_valid, seen.evicted_id);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("FAIL bounded_job_stack_with_eviction");
      $finish;
    end
  end

endmodule
